[design/sexl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sexl_pkg
// Shared types, constants and character helpers for the S-expression lexer.
// ----------------------------------------------------------------------------
package sexl_pkg;

	localparam int unsigned NEST_DEPTH_BITS_DEF = 16;
	localparam int unsigned OFFSET_BITS_DEF = 32;
	localparam int unsigned MAX_RES = 4;

	typedef enum logic [3:0] {
		K_LPAREN = 4'd0, K_RPAREN = 4'd1, K_STRING = 4'd2, K_POUND = 4'd3,
		K_CHAR = 4'd4, K_SYMBOL = 4'd5, K_INTEGER = 4'd6, K_ERROR = 4'd7,
		K_END = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE = 3'd0, E_UNCL_COMMENT = 3'd1, E_BAD_STR_ESC = 3'd2,
		E_UNCL_STRING = 3'd3, E_UNCL_CHAR = 3'd4, E_EMPTY_CHAR = 3'd5,
		E_BAD_CHAR_ESC = 3'd6
	} err_t;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_STR, M_STR_ESC, M_POUND, M_CH_OPEN, M_CH_ESC,
		M_CH_CLOSE, M_BLOCK, M_B_HASH, M_B_PIPE, M_LCOMMENT
	} mode_t;

	typedef enum logic [2:0] {
		P_DEC = 3'd0, P_SIGN = 3'd1, P_ZERO = 3'd2, P_PREFIX = 3'd3,
		P_DIGITS = 3'd4, P_BAD = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		R_DEC = 2'd0, R_BIN = 2'd1, R_OCT = 2'd2, R_HEX = 2'd3
	} radix_t;

	localparam logic [7:0] C_LF = 8'd10;
	localparam logic [7:0] C_CR = 8'd13;
	localparam logic [7:0] C_TAB = 8'd9;
	localparam logic [7:0] C_HASH = 8'h23;
	localparam logic [7:0] C_PIPE = 8'h7c;
	localparam logic [7:0] C_SEMI = 8'h3b;
	localparam logic [7:0] C_QUOTE = 8'h22;
	localparam logic [7:0] C_APOS = 8'h27;
	localparam logic [7:0] C_BSL = 8'h5c;

	typedef struct packed {
		kind_t kind;
		logic [31:0] start_offset;
		logic [31:0] token_length;
		logic [31:0] line_number;
		logic [63:0] token_value;
		err_t error_code;
	} result_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c == C_CR || c == C_LF || c == C_TAB || c == 8'h20 || c == C_HASH ||
			c == C_QUOTE || c == 8'h28 || c == 8'h29 || c == C_SEMI;
	endfunction

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
		return 5'd16;
	endfunction

	function automatic logic in_set(input logic [7:0] c);
		return digit_of(c) != 5'd16 || c == 8'h2b || c == 8'h2d || c == 8'h5f ||
			c == 8'h6f || c == 8'h78;
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage
`default_nettype wire

[design/sexl_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sexl_core
// Lexer state and per-byte token logic; yields up to four results per byte.
// ----------------------------------------------------------------------------
module sexl_core #(
	parameter int unsigned NEST_DEPTH_BITS = 16,
	parameter int unsigned OFFSET_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic [7:0] c,
	input  wire logic fin,
	output sexl_pkg::result_t res [sexl_pkg::MAX_RES],
	output logic [2:0] res_count
);
	import sexl_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [NEST_DEPTH_BITS-1:0] DEPTH_MAX = '1;

	mode_t mode_q, mode_n;
	logic [OFFSET_BITS-1:0] pos_q, start_q, start_n, pos_inc;
	logic [31:0] line_q, line_n, tline_q, tline_n;
	logic [63:0] acc_q, acc_n;
	logic neg_q, neg_n;
	radix_t rad_q, rad_n;
	phase_t ph_q, ph_n;
	logic [NEST_DEPTH_BITS-1:0] depth_q, depth_n;
	logic [7:0] chv_q, chv_n;
	result_t r [MAX_RES];
	logic [2:0] n;

	function automatic logic [OFFSET_BITS-1:0] oinc(input logic [OFFSET_BITS-1:0] v);
		return (v == OFF_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [63:0] wide(input logic [OFFSET_BITS-1:0] v);
		return 64'(v);
	endfunction

	always_comb begin
		logic [OFFSET_BITS-1:0] endp;
		logic [63:0] m10;
		logic [4:0] d;
		logic [4:0] radn;
		logic again;
		mode_t m;
		result_t e;
		m = mode_q;
		start_n = start_q; tline_n = tline_q; line_n = line_q;
		acc_n = acc_q; neg_n = neg_q; rad_n = rad_q; ph_n = ph_q;
		depth_n = depth_q; chv_n = chv_q;
		pos_inc = oinc(pos_q);
		n = 3'd0;
		again = 1'b0;
		endp = '0; m10 = '0; d = '0; radn = '0;
		for (int i = 0; i < MAX_RES; i++) r[i] = '0;
		e = '0;
		// First pass over the current mode; may hand the byte back to idle.
		unique case (m)
			M_WORD: begin
				if (is_delim(c)) begin
					again = 1'b1;
					m = M_IDLE;
					e.start_offset = sat32(wide(start_q));
					e.token_length = sat32(wide(pos_q >= start_q ? pos_q - start_q : '0));
					e.line_number = tline_q;
					if (ph_q == P_DEC || ph_q == P_DIGITS || ph_q == P_ZERO) begin
						e.kind = K_INTEGER;
						e.token_value = neg_q ? 64'(0) - acc_q : acc_q;
					end else begin
						e.kind = K_SYMBOL;
					end
					r[0] = e; n = 3'd1;
				end else if (!in_set(c)) begin
					ph_n = P_BAD;
				end else begin
					d = digit_of(c);
					radn = (rad_q == R_DEC) ? 5'd10 : (rad_q == R_BIN) ? 5'd2 :
						(rad_q == R_OCT) ? 5'd8 : 5'd16;
					m10 = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
					unique case (ph_q)
						P_SIGN: begin
							if (c == 8'h30) ph_n = P_ZERO;
							else if (c >= 8'h31 && c <= 8'h39) begin
								ph_n = P_DEC; acc_n = 64'(c - 8'h30);
							end else ph_n = P_BAD;
						end
						P_ZERO: begin
							if (c == 8'h62 || c == 8'h6f || c == 8'h78) begin
								rad_n = (c == 8'h62) ? R_BIN : (c == 8'h6f) ? R_OCT : R_HEX;
								ph_n = P_PREFIX;
							end else begin
								ph_n = P_DEC;
								if (c != 8'h5f) begin
									if (d >= 5'd10) ph_n = P_BAD;
									else acc_n = m10 + 64'(d);
								end
							end
						end
						P_PREFIX, P_DEC, P_DIGITS: begin
							if (ph_q == P_PREFIX && c != 8'h5f) ph_n = P_DIGITS;
							if (c != 8'h5f) begin
								if (d >= radn) ph_n = P_BAD;
								else begin
									unique case (rad_q)
										R_DEC: acc_n = m10 + 64'(d);
										R_BIN: acc_n = {acc_q[62:0], 1'b0} + 64'(d);
										R_OCT: acc_n = {acc_q[60:0], 3'b0} + 64'(d);
										R_HEX: acc_n = {acc_q[59:0], 4'b0} + 64'(d);
									endcase
								end
							end
						end
						default: ;
					endcase
				end
			end
			M_POUND: begin
				if (c == C_PIPE) begin m = M_BLOCK; depth_n = '0; end
				else if (c == C_APOS) m = M_CH_OPEN;
				else begin
					e.kind = K_POUND;
					e.start_offset = sat32(wide(start_q));
					e.token_length = sat32(wide(pos_q >= start_q ? pos_q - start_q : '0));
					e.line_number = tline_q;
					r[0] = e; n = 3'd1;
					m = M_IDLE; again = 1'b1;
				end
			end
			M_CH_OPEN: begin
				if (c == C_APOS) begin
					e.kind = K_CHAR; e.error_code = E_EMPTY_CHAR;
					e.start_offset = sat32(wide(start_q));
					e.token_length = sat32(wide(pos_inc >= start_q ? pos_inc - start_q : '0));
					e.line_number = tline_q;
					r[0] = e; n = 3'd1; m = M_IDLE;
				end else if (c == C_BSL) m = M_CH_ESC;
				else begin
					if (c == C_LF && line_q != '1) line_n = line_q + 1'b1;
					chv_n = c; m = M_CH_CLOSE;
				end
			end
			M_CH_ESC: begin
				chv_n = c;
				unique case (c)
					C_BSL, C_APOS: ;
					8'h72: chv_n = 8'd13;
					8'h6e: chv_n = 8'd10;
					8'h74: chv_n = 8'd9;
					8'h30: chv_n = 8'd0;
					default: begin
						if (c == C_LF && line_q != '1) line_n = line_q + 1'b1;
						e.kind = K_ERROR; e.error_code = E_BAD_CHAR_ESC;
						e.start_offset = sat32(wide(start_q));
						e.token_length = sat32(wide(pos_inc >= start_q ? pos_inc - start_q : '0));
						e.line_number = tline_q; e.token_value = 64'(c);
						r[0] = e; n = 3'd1;
					end
				endcase
				m = M_CH_CLOSE;
			end
			M_CH_CLOSE: begin
				m = M_IDLE;
				e.kind = K_CHAR; e.start_offset = sat32(wide(start_q));
				e.line_number = tline_q; e.token_value = 64'(chv_q);
				if (c == C_APOS) begin
					e.token_length = sat32(wide(pos_inc >= start_q ? pos_inc - start_q : '0));
				end else begin
					e.token_length = sat32(wide(pos_q >= start_q ? pos_q - start_q : '0));
					e.error_code = E_UNCL_CHAR; again = 1'b1;
				end
				r[0] = e; n = 3'd1;
			end
			M_STR: begin
				if (c == C_BSL) m = M_STR_ESC;
				else if (c == C_LF) begin
					if (line_q != '1) line_n = line_q + 1'b1;
				end else if (c == C_QUOTE) begin
					e.kind = K_STRING; e.start_offset = sat32(wide(start_q));
					e.token_length = sat32(wide(pos_q > start_q ? pos_q - start_q - 1'b1 : '0));
					e.line_number = tline_q; e.token_value = wide(oinc(start_q));
					r[0] = e; n = 3'd1; m = M_IDLE;
				end
			end
			M_STR_ESC: begin
				if (!(c == 8'h72 || c == 8'h6e || c == 8'h74 || c == 8'h30 ||
					c == C_BSL || c == C_QUOTE)) begin
					if (c == C_LF && line_q != '1) line_n = line_q + 1'b1;
					e.kind = K_ERROR; e.error_code = E_BAD_STR_ESC;
					e.start_offset = sat32(wide(start_q));
					e.token_length = sat32(wide(pos_inc >= start_q ? pos_inc - start_q : '0));
					e.line_number = tline_q; e.token_value = 64'(c);
					r[0] = e; n = 3'd1;
				end
				m = M_STR;
			end
			M_LCOMMENT: begin
				if (c == C_LF) begin m = M_IDLE; again = 1'b1; end
			end
			M_BLOCK: begin
				if (c == C_LF) begin
					if (line_q != '1) line_n = line_q + 1'b1;
				end else if (c == C_HASH) m = M_B_HASH;
				else if (c == C_PIPE) m = M_B_PIPE;
			end
			M_B_HASH: begin
				m = M_BLOCK;
				if (c == C_PIPE) begin
					if (depth_q != DEPTH_MAX) depth_n = depth_q + 1'b1;
				end else again = 1'b1;
			end
			M_B_PIPE: begin
				m = M_BLOCK;
				if (c == C_HASH) begin
					if (depth_q == '0) m = M_IDLE;
					else depth_n = depth_q - 1'b1;
				end else again = 1'b1;
			end
			default: again = 1'b1;
		endcase
		// Second pass: block-comment bytes re-enter block mode, which cannot
		// itself redirect, so the idle handling below is skipped for them.
		if (again && m == M_BLOCK) begin
			again = 1'b0;
			if (c == C_LF) begin
				if (line_q != '1) line_n = line_q + 1'b1;
			end else if (c == C_HASH) m = M_B_HASH;
			else if (c == C_PIPE) m = M_B_PIPE;
		end
		if (again) begin
			start_n = pos_q; tline_n = line_q; m = M_IDLE;
			e = '0; e.start_offset = sat32(wide(pos_q)); e.line_number = line_q;
			e.token_length = 32'd1;
			unique case (c)
				8'h28: begin e.kind = K_LPAREN; r[n[1:0]] = e; n = n + 3'd1; end
				8'h29: begin e.kind = K_RPAREN; r[n[1:0]] = e; n = n + 3'd1; end
				C_QUOTE: m = M_STR;
				C_HASH: m = M_POUND;
				C_SEMI: m = M_LCOMMENT;
				8'h20, C_TAB, C_CR: ;
				C_LF: if (line_q != '1) line_n = line_q + 1'b1;
				default: begin
					m = M_WORD; acc_n = '0; neg_n = 1'b0; rad_n = R_DEC; ph_n = P_BAD;
					if (c == 8'h2d) begin ph_n = P_SIGN; neg_n = 1'b1; end
					else if (c == 8'h2b) ph_n = P_SIGN;
					else if (c == 8'h30) ph_n = P_ZERO;
					else if (c >= 8'h31 && c <= 8'h39) begin
						ph_n = P_DEC; acc_n = 64'(c - 8'h30);
					end
				end
			endcase
		end
		mode_n = m;
		if (fin) begin
			endp = pos_inc;
			e = '0;
			e.start_offset = sat32(wide(start_n));
			e.line_number = tline_n;
			e.token_length = sat32(wide(endp >= start_n ? endp - start_n : '0));
			unique case (m)
				M_WORD: begin
					if (ph_n == P_DEC || ph_n == P_DIGITS || ph_n == P_ZERO) begin
						e.kind = K_INTEGER; e.token_value = neg_n ? 64'(0) - acc_n : acc_n;
					end else e.kind = K_SYMBOL;
					r[n[1:0]] = e; n = n + 3'd1;
				end
				M_POUND: begin e.kind = K_POUND; r[n[1:0]] = e; n = n + 3'd1; end
				M_CH_OPEN, M_CH_ESC: begin
					e.kind = K_ERROR; e.error_code = E_UNCL_CHAR;
					r[n[1:0]] = e; n = n + 3'd1;
				end
				M_CH_CLOSE: begin
					e.kind = K_CHAR; e.error_code = E_UNCL_CHAR; e.token_value = 64'(chv_n);
					r[n[1:0]] = e; n = n + 3'd1;
				end
				M_STR, M_STR_ESC: begin
					e.kind = K_STRING; e.error_code = E_UNCL_STRING;
					e.token_length = sat32(wide(endp > start_n ? endp - start_n - 1'b1 : '0));
					e.token_value = wide(oinc(start_n));
					r[n[1:0]] = e; n = n + 3'd1;
				end
				M_BLOCK, M_B_HASH, M_B_PIPE: begin
					e.kind = K_ERROR; e.error_code = E_UNCL_COMMENT;
					r[n[1:0]] = e; n = n + 3'd1;
				end
				default: ;
			endcase
			e = '0; e.kind = K_END; e.start_offset = sat32(wide(endp));
			e.line_number = line_n;
			r[n[1:0]] = e; n = n + 3'd1;
		end
	end

	assign res = r;
	assign res_count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pos_q <= '0; line_q <= '0; start_q <= '0; tline_q <= '0;
			acc_q <= '0; neg_q <= 1'b0; rad_q <= R_DEC; ph_q <= P_DEC;
			depth_q <= '0; chv_q <= '0;
		end else if (step) begin
			if (fin) begin
				mode_q <= M_IDLE; pos_q <= '0; line_q <= '0; start_q <= '0; tline_q <= '0;
				acc_q <= '0; neg_q <= 1'b0; rad_q <= R_DEC; ph_q <= P_DEC;
				depth_q <= '0; chv_q <= '0;
			end else begin
				mode_q <= mode_n; pos_q <= pos_inc; line_q <= line_n;
				start_q <= start_n; tline_q <= tline_n; acc_q <= acc_n; neg_q <= neg_n;
				rad_q <= rad_n; ph_q <= ph_n; depth_q <= depth_n; chv_q <= chv_n;
			end
		end
	end
endmodule
`default_nettype wire

[design/sexl_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sexl_outq
// Result queue: takes a group of results per byte and sends one per beat.
// ----------------------------------------------------------------------------
module sexl_outq (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire sexl_pkg::result_t res [sexl_pkg::MAX_RES],
	input  wire logic [2:0] res_count,
	output logic can_push,
	output logic out_valid,
	input  wire logic out_ready,
	output sexl_pkg::result_t head,
	output logic head_last
);
	import sexl_pkg::*;

	localparam int unsigned DEPTH = 8;

	result_t mem_q [DEPTH];
	logic last_q [DEPTH];
	logic [2:0] rd_q, wr_q;
	logic [3:0] cnt_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 4'd0;
	assign head = mem_q[rd_q];
	assign head_last = last_q[rd_q];
	assign can_push = cnt_q <= 4'(DEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (3'(i) < res_count) begin
					mem_q[wr_q + 3'(i)] <= res[i];
					last_q[wr_q + 3'(i)] <= (3'(i + 1) == res_count);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + res_count;
			if (pop) rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + (push ? {1'b0, res_count} : 4'd0) - (pop ? 4'd1 : 4'd0);
		end
	end
endmodule
`default_nettype wire

[design/sexpr_lexer_byte_stream_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sexpr_lexer_byte_stream_unit
// S-expression lexer: one source byte per beat in, token results out.
// ----------------------------------------------------------------------------
// The results of a byte are registered in the result queue before they leave.
// Throughput: one byte per cycle while the eight-entry result queue has room
// for four more results; results leave at one per cycle while out_ready is high.
// Reset clears lexer state and the queue; final_byte also returns the lexer state to reset.
module sexpr_lexer_byte_stream_unit #(
	parameter int unsigned NEST_DEPTH_BITS = sexl_pkg::NEST_DEPTH_BITS_DEF,
	parameter int unsigned OFFSET_BITS = sexl_pkg::OFFSET_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [7:0] byte_in,
	input  wire logic final_byte,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [3:0] kind,
	output logic [31:0] start_offset,
	output logic [31:0] token_length,
	output logic [31:0] line_number,
	output logic [63:0] token_value,
	output logic [2:0] error_code,
	output logic last_of_run
);
	import sexl_pkg::*;

	result_t res [MAX_RES];
	result_t head;
	logic [2:0] res_count;
	logic step;

	assign step = in_valid && in_ready;

	sexl_core #(.NEST_DEPTH_BITS(NEST_DEPTH_BITS), .OFFSET_BITS(OFFSET_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .c(byte_in), .fin(final_byte),
		.res(res), .res_count(res_count)
	);

	sexl_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(step), .res(res), .res_count(res_count),
		.can_push(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.head(head), .head_last(last_of_run)
	);

	assign kind = head.kind;
	assign start_offset = head.start_offset;
	assign token_length = head.token_length;
	assign line_number = head.line_number;
	assign token_value = head.token_value;
	assign error_code = head.error_code;
endmodule
`default_nettype wire

[tb/sv/tb_sexpr_lexer_byte_stream_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sexpr_lexer_byte_stream_unit
// Feeds source text into the S-expression lexer one byte per beat and checks
// every token against a behavioural lexer kept in step inside the bench.
// ----------------------------------------------------------------------------
module tb_sexpr_lexer_byte_stream_unit;
	import sexl_pkg::*;

	localparam logic [7:0] C_SPACE = 8'h20;
	localparam logic [7:0] C_LPAR = 8'h28;
	localparam logic [7:0] C_RPAR = 8'h29;
	localparam logic [5:0] NEG_FLAG = 6'h20;
	localparam logic [63:0] OFF_TOP = 64'hFFFF_FFFF;
	localparam logic [63:0] DEPTH_TOP = 64'hFFFF;

	typedef struct {
		kind_t kind;
		logic [31:0] start_offset;
		logic [31:0] token_length;
		logic [31:0] line_number;
		logic [63:0] token_value;
		err_t error_code;
		logic last_of_run;
	} token_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] byte_in = 8'd0;
	logic final_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] kind;
	logic [31:0] start_offset, token_length, line_number;
	logic [63:0] token_value;
	logic [2:0] error_code;
	logic last_of_run;

	token_rec_t expected_tokens[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;

	mode_t lx_mode;
	logic [63:0] lx_pos, lx_line, lx_start, lx_tline, lx_acc, lx_depth;
	logic [5:0] lx_flags;
	logic [7:0] lx_chr;
	token_rec_t step_out[$];

	always #4 clk = ~clk;

	sexpr_lexer_byte_stream_unit dut (.*);

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles > 4000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [31:0] sat(logic [63:0] v);
		return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [63:0] incr(logic [63:0] v);
		return v >= OFF_TOP ? OFF_TOP : v + 1;
	endfunction

	function automatic logic [63:0] span(logic [63:0] e);
		return e >= lx_start ? e - lx_start : 0;
	endfunction

	task automatic emit(kind_t k, logic [63:0] st, logic [63:0] ln, logic [63:0] li,
			logic [63:0] v, err_t e);
		token_rec_t r;
		if (step_out.size() >= MAX_RES) return;
		r.kind = k; r.start_offset = sat(st); r.token_length = sat(ln);
		r.line_number = sat(li); r.token_value = v; r.error_code = e;
		r.last_of_run = 1'b0;
		step_out.push_back(r);
	endtask

	task automatic lexer_reset();
		lx_mode = M_IDLE; lx_pos = 0; lx_line = 0; lx_start = 0; lx_tline = 0;
		lx_acc = 0; lx_flags = 0; lx_depth = 0; lx_chr = 0;
	endtask

	function automatic bit delim(logic [7:0] c);
		return c == C_CR || c == C_LF || c == C_TAB || c == C_SPACE || c == C_HASH ||
			c == C_QUOTE || c == C_LPAR || c == C_RPAR || c == C_SEMI;
	endfunction

	function automatic int unsigned dval(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	function automatic void set_ph(phase_t p);
		lx_flags[2:0] = p;
	endfunction

	function automatic void add_digit(logic [7:0] c);
		radix_t rc;
		int unsigned d, rad;
		rc = radix_t'(lx_flags[4:3]);
		rad = rc == R_DEC ? 10 : rc == R_BIN ? 2 : rc == R_OCT ? 8 : 16;
		if (c == "_") return;
		d = dval(c);
		if (d >= rad) begin
			set_ph(P_BAD);
			return;
		end
		case (rc)
			R_DEC: lx_acc = lx_acc * 10 + d;
			R_BIN: lx_acc = (lx_acc << 1) + d;
			R_OCT: lx_acc = (lx_acc << 3) + d;
			default: lx_acc = (lx_acc << 4) + d;
		endcase
	endfunction

	function automatic void word_start(logic [7:0] c);
		lx_acc = 0;
		lx_flags = P_BAD;
		if (c == "-") lx_flags = NEG_FLAG | P_SIGN;
		else if (c == "+") lx_flags = P_SIGN;
		else if (c == "0") lx_flags = P_ZERO;
		else if (c >= "1" && c <= "9") begin
			lx_flags = P_DEC;
			lx_acc = c - "0";
		end
	endfunction

	function automatic void word_byte(logic [7:0] c);
		bit ok;
		ok = dval(c) != 16 || c == "+" || c == "-" || c == "_" || c == "o" || c == "x";
		if (!ok) begin
			set_ph(P_BAD);
			return;
		end
		case (phase_t'(lx_flags[2:0]))
			P_SIGN: begin
				if (c == "0") set_ph(P_ZERO);
				else if (c >= "1" && c <= "9") begin
					set_ph(P_DEC);
					lx_acc = c - "0";
				end else set_ph(P_BAD);
			end
			P_ZERO: begin
				if (c == "b" || c == "o" || c == "x") begin
					lx_flags = (lx_flags & NEG_FLAG) | P_PREFIX;
					lx_flags[4:3] = c == "b" ? R_BIN : c == "o" ? R_OCT : R_HEX;
				end else begin
					set_ph(P_DEC);
					add_digit(c);
				end
			end
			P_PREFIX: begin
				if (c != "_") begin
					set_ph(P_DIGITS);
					add_digit(c);
				end
			end
			P_DEC, P_DIGITS: add_digit(c);
			default: ;
		endcase
	endfunction

	task automatic word_end(logic [63:0] e);
		phase_t p;
		logic [63:0] v;
		p = phase_t'(lx_flags[2:0]);
		if (p == P_DEC || p == P_DIGITS || p == P_ZERO) begin
			v = lx_acc;
			if (lx_flags[5]) v = 64'd0 - v;
			emit(K_INTEGER, lx_start, span(e), lx_tline, v, E_NONE);
		end else emit(K_SYMBOL, lx_start, span(e), lx_tline, 0, E_NONE);
	endtask

	function automatic void line_up();
		if (lx_line < 64'hFFFF_FFFF) lx_line++;
	endfunction

	task automatic lex_byte(logic [7:0] c, logic [63:0] p, output bit again);
		logic [7:0] v;
		again = 0;
		case (lx_mode)
			M_WORD: begin
				if (delim(c)) begin
					word_end(p);
					lx_mode = M_IDLE;
					again = 1;
				end else word_byte(c);
			end
			M_POUND: begin
				if (c == C_PIPE) begin
					lx_mode = M_BLOCK;
					lx_depth = 0;
				end else if (c == C_APOS) lx_mode = M_CH_OPEN;
				else begin
					emit(K_POUND, lx_start, span(p), lx_tline, 0, E_NONE);
					lx_mode = M_IDLE;
					again = 1;
				end
			end
			M_CH_OPEN: begin
				if (c == C_APOS) begin
					emit(K_CHAR, lx_start, span(incr(p)), lx_tline, 0, E_EMPTY_CHAR);
					lx_mode = M_IDLE;
				end else if (c == C_BSL) lx_mode = M_CH_ESC;
				else begin
					if (c == C_LF) line_up();
					lx_chr = c;
					lx_mode = M_CH_CLOSE;
				end
			end
			M_CH_ESC: begin
				v = c;
				if (c == "r") v = 13;
				else if (c == "n") v = 10;
				else if (c == "t") v = 9;
				else if (c == "0") v = 0;
				else if (c != C_BSL && c != C_APOS) begin
					if (c == C_LF) line_up();
					emit(K_ERROR, lx_start, span(incr(p)), lx_tline, c, E_BAD_CHAR_ESC);
				end
				lx_chr = v;
				lx_mode = M_CH_CLOSE;
			end
			M_CH_CLOSE: begin
				lx_mode = M_IDLE;
				if (c == C_APOS)
					emit(K_CHAR, lx_start, span(incr(p)), lx_tline, lx_chr, E_NONE);
				else begin
					emit(K_CHAR, lx_start, span(p), lx_tline, lx_chr, E_UNCL_CHAR);
					again = 1;
				end
			end
			M_STR: begin
				if (c == C_BSL) lx_mode = M_STR_ESC;
				else if (c == C_LF) line_up();
				else if (c == C_QUOTE) begin
					emit(K_STRING, lx_start, p > lx_start ? p - lx_start - 1 : 0, lx_tline,
						incr(lx_start), E_NONE);
					lx_mode = M_IDLE;
				end
			end
			M_STR_ESC: begin
				if (!(c == "r" || c == "n" || c == "t" || c == "0" || c == C_BSL ||
						c == C_QUOTE)) begin
					if (c == C_LF) line_up();
					emit(K_ERROR, lx_start, span(incr(p)), lx_tline, c, E_BAD_STR_ESC);
				end
				lx_mode = M_STR;
			end
			M_LCOMMENT: begin
				if (c == C_LF) begin
					lx_mode = M_IDLE;
					again = 1;
				end
			end
			M_BLOCK: begin
				if (c == C_LF) line_up();
				else if (c == C_HASH) lx_mode = M_B_HASH;
				else if (c == C_PIPE) lx_mode = M_B_PIPE;
			end
			M_B_HASH: begin
				lx_mode = M_BLOCK;
				if (c == C_PIPE) begin
					if (lx_depth < DEPTH_TOP) lx_depth++;
				end else again = 1;
			end
			M_B_PIPE: begin
				lx_mode = M_BLOCK;
				if (c == C_HASH) begin
					if (lx_depth == 0) lx_mode = M_IDLE;
					else lx_depth--;
				end else again = 1;
			end
			default: begin
				lx_start = p;
				lx_tline = lx_line;
				lx_mode = M_IDLE;
				if (c == C_LPAR) emit(K_LPAREN, p, 1, lx_tline, 0, E_NONE);
				else if (c == C_RPAR) emit(K_RPAREN, p, 1, lx_tline, 0, E_NONE);
				else if (c == C_QUOTE) lx_mode = M_STR;
				else if (c == C_HASH) lx_mode = M_POUND;
				else if (c == C_SEMI) lx_mode = M_LCOMMENT;
				else if (c == C_LF) line_up();
				else if (!(c == C_SPACE || c == C_TAB || c == C_CR)) begin
					lx_mode = M_WORD;
					word_start(c);
				end
			end
		endcase
	endtask

	task automatic predict_tokens(logic [7:0] c, bit fin);
		bit again;
		logic [63:0] p, e;
		step_out.delete();
		p = lx_pos;
		do lex_byte(c, p, again); while (again);
		lx_pos = incr(p);
		if (fin) begin
			e = lx_pos;
			case (lx_mode)
				M_WORD: word_end(e);
				M_POUND: emit(K_POUND, lx_start, span(e), lx_tline, 0, E_NONE);
				M_CH_OPEN, M_CH_ESC:
					emit(K_ERROR, lx_start, span(e), lx_tline, 0, E_UNCL_CHAR);
				M_CH_CLOSE: emit(K_CHAR, lx_start, span(e), lx_tline, lx_chr, E_UNCL_CHAR);
				M_STR, M_STR_ESC:
					emit(K_STRING, lx_start, e > lx_start ? e - lx_start - 1 : 0, lx_tline,
						incr(lx_start), E_UNCL_STRING);
				M_BLOCK, M_B_HASH, M_B_PIPE:
					emit(K_ERROR, lx_start, span(e), lx_tline, 0, E_UNCL_COMMENT);
				default: ;
			endcase
			emit(K_END, e, 0, lx_line, 0, E_NONE);
			lexer_reset();
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
		foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
	endtask

	task automatic send_byte(logic [7:0] c, bit fin = 0);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= c;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		predict_tokens(c, fin);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit fin = 1);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		token_rec_t x;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token kind %0d", kind);
				errors++;
			end else begin
				x = expected_tokens.pop_front();
				if (kind !== x.kind) begin
					$error("kind exp %0d got %0d", x.kind, kind); errors++;
				end
				if (start_offset !== x.start_offset) begin
					$error("start_offset exp %0d got %0d", x.start_offset, start_offset);
					errors++;
				end
				if (token_length !== x.token_length) begin
					$error("token_length exp %0d got %0d", x.token_length, token_length);
					errors++;
				end
				if (line_number !== x.line_number) begin
					$error("line_number exp %0d got %0d", x.line_number, line_number);
					errors++;
				end
				if (token_value !== x.token_value) begin
					$error("token_value exp %h got %h", x.token_value, token_value);
					errors++;
				end
				if (error_code !== x.error_code) begin
					$error("error_code exp %0d got %0d", x.error_code, error_code);
					errors++;
				end
				if (last_of_run !== x.last_of_run) begin
					$error("last_of_run exp %0d got %0d", x.last_of_run, last_of_run);
					errors++;
				end
			end
		end
	end

	task automatic test_punctuation();
		send_text("( ) #x #", 1);
		send_text("\t\r\n;note\n(\"ab\\q\\\nc\" #|a#|b|#c|#)", 1);
	endtask

	task automatic test_numbers();
		send_text("-0x7F 0b1_0 0o777 +12_3 0 0x_Ab -18446744073709551617 1a", 1);
		send_text("sym", 1);
	endtask

	task automatic test_chars();
		send_text("#'a' #'\\n' #'\\q' #'' #'ab #'\\\\'", 1);
		send_text("#'", 1);
		send_text("#'\\", 1);
		send_text("\"open\\", 1);
		send_text("#|#|x|#", 1);
		send_byte(8'hFF, 1);
		send_byte(8'h00, 1);
	endtask

	function automatic string random_piece();
		string alpha = "0123456789abcdefABCDEFoxb_+-zq";
		string s;
		int n;
		case ($urandom_range(0, 11))
			0: return "(";
			1: return ")";
			2: return " ";
			3: return "\n";
			4: return ";c\n";
			5: return "#|z #|y|# |#";
			6: return $sformatf("#'%c'", 8'($urandom_range(33, 126)));
			7: return "#'\\t'";
			8: return "\"s\\n\\w\"";
			9: return $sformatf("0x%h ", 16'($urandom));
			default: begin
				s = "";
				n = $urandom_range(1, 6);
				repeat (n) s = {s, string'(alpha[$urandom_range(0, alpha.len() - 1)])};
				return s;
			end
		endcase
	endfunction

	task automatic test_random_text();
		int sent;
		string s;
		sent = 0;
		while (sent < 180) begin
			if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom), $urandom_range(0, 15) == 0);
				sent++;
			end else begin
				s = random_piece();
				send_text(s, $urandom_range(0, 20) == 0);
				sent += s.len();
			end
			if (sent > 140) calm = 1;
		end
		send_text(" ", 1);
	endtask

	initial begin
		lexer_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_punctuation();
		test_numbers();
		test_chars();
		test_random_text();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
design/sexl_pkg.sv
design/sexl_core.sv
design/sexl_outq.sv
design/sexpr_lexer_byte_stream_unit.sv
tb/sv/tb_sexpr_lexer_byte_stream_unit.sv
